### src/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define HTLD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("htld assertion failed");

// Check that cond in one cycle is followed by conseq in the next.
`define HTLD_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("htld assertion failed");

`endif

### src/htld_pkg.sv
package htld_pkg;

	localparam int NODE_SLOTS  = 512;
	localparam int STACK_SLOTS = 256;

	localparam int NODE_IDX_W  = $clog2(NODE_SLOTS);
	localparam int NODE_CNT_W  = $clog2(NODE_SLOTS + 1);
	localparam int STACK_IDX_W = $clog2(STACK_SLOTS);
	localparam int STACK_CNT_W = $clog2(STACK_SLOTS + 1);

	typedef logic [NODE_IDX_W-1:0]  node_idx_t;
	typedef logic [NODE_CNT_W-1:0]  node_cnt_t;
	typedef logic [STACK_IDX_W-1:0] stack_idx_t;
	typedef logic [STACK_CNT_W-1:0] stack_cnt_t;

	typedef struct packed {
		logic      leaf;
		logic [7:0] sym;
		node_idx_t left;
		node_idx_t right;
	} node_t;

	typedef enum logic [1:0] {
		KIND_SYMBOL   = 2'd0,
		KIND_HDR_DONE = 2'd1,
		KIND_HDR_ERR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_FLAG   = 2'd0,
		PH_SYMBOL = 2'd1,
		PH_DECODE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_MERGE = 2'd1,
		ST_WALK  = 2'd2
	} state_t;

	localparam logic [7:0] FLAG_END  = 8'd0;
	localparam logic [7:0] FLAG_LEAF = 8'd1;

endpackage

### src/huffman_tree_load_and_decode.sv
// Header flag, symbol byte, header end and header error: result (if any) registered, on the
// cycle after the accepting edge. Merge flag: build stack read, then write back in ST_MERGE.
// Code bit: result from the current node if it is a leaf, else via a node store read in ST_WALK.
// The receiver cannot stall; busy is high only while in ST_MERGE or ST_WALK.
// arst_n clears control state and the loader; node store and build stack are not cleared.
module huffman_tree_load_and_decode (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       req_type,
	input  logic [7:0] data,
	output logic       valid,
	output logic [1:0] kind,
	output logic [7:0] symbol
);

	htld_pkg::node_t node_mem [htld_pkg::NODE_SLOTS];
	htld_pkg::node_idx_t stack_mem [htld_pkg::STACK_SLOTS];

	htld_pkg::state_t     state_q, state_d;
	htld_pkg::phase_t     phase_q, phase_d;
	htld_pkg::stack_cnt_t sc_q, sc_d;
	htld_pkg::node_cnt_t  nc_q, nc_d;
	logic                 valid_q, valid_d;

	htld_pkg::node_t     cur_node_q, cur_node_d;
	htld_pkg::node_t     root_node_q, root_node_d;
	htld_pkg::node_t     top_node_q, top_node_d;
	htld_pkg::node_idx_t top_idx_q, top_idx_d;
	logic [1:0]          kind_q, kind_d;
	logic [7:0]          symbol_q, symbol_d;

	logic                 node_we;
	htld_pkg::node_idx_t  node_waddr, node_raddr;
	htld_pkg::node_t      node_wdata, node_rd_q;
	logic                 stack_we;
	htld_pkg::stack_idx_t stack_waddr, stack_raddr;
	htld_pkg::node_idx_t  stack_wdata, stack_rd_q;

	htld_pkg::phase_t     ph;
	htld_pkg::stack_cnt_t sc;
	htld_pkg::node_cnt_t  nc;
	htld_pkg::node_t      new_node;
	logic                 node_full, stack_full;

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_waddr] <= node_wdata;
		end
		node_rd_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		stack_rd_q <= stack_mem[stack_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htld_pkg::ST_IDLE;
			phase_q <= htld_pkg::PH_FLAG;
			sc_q    <= '0;
			nc_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			sc_q    <= sc_d;
			nc_q    <= nc_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_node_q  <= cur_node_d;
		root_node_q <= root_node_d;
		top_node_q  <= top_node_d;
		top_idx_q   <= top_idx_d;
		kind_q      <= kind_d;
		symbol_q    <= symbol_d;
	end

	always_comb begin
		state_d     = state_q;
		phase_d     = phase_q;
		sc_d        = sc_q;
		nc_d        = nc_q;
		valid_d     = 1'b0;
		kind_d      = htld_pkg::KIND_SYMBOL;
		symbol_d    = '0;
		cur_node_d  = cur_node_q;
		root_node_d = root_node_q;
		top_node_d  = top_node_q;
		top_idx_d   = top_idx_q;
		node_we     = 1'b0;
		node_waddr  = nc_q[htld_pkg::NODE_IDX_W-1:0];
		node_wdata  = top_node_q;
		node_raddr  = data[0] ? cur_node_q.right : cur_node_q.left;
		stack_we    = 1'b0;
		stack_waddr = sc_q[htld_pkg::STACK_IDX_W-1:0];
		stack_wdata = nc_q[htld_pkg::NODE_IDX_W-1:0];
		stack_raddr = htld_pkg::stack_idx_t'(sc_q - htld_pkg::stack_cnt_t'(2));
		new_node    = '0;

		// Drop the loaded tree when a header byte arrives while decoding.
		ph = (phase_q == htld_pkg::PH_DECODE) ? htld_pkg::PH_FLAG : phase_q;
		sc = (phase_q == htld_pkg::PH_DECODE) ? '0 : sc_q;
		nc = (phase_q == htld_pkg::PH_DECODE) ? '0 : nc_q;
		node_full  = nc >= htld_pkg::node_cnt_t'(htld_pkg::NODE_SLOTS);
		stack_full = sc >= htld_pkg::stack_cnt_t'(htld_pkg::STACK_SLOTS);

		case (state_q)
			htld_pkg::ST_IDLE: begin
				if (start && req_type) begin
					if (phase_q == htld_pkg::PH_DECODE) begin
						if (cur_node_q.leaf) begin
							valid_d    = 1'b1;
							symbol_d   = cur_node_q.sym;
							cur_node_d = root_node_q;
						end else begin
							state_d = htld_pkg::ST_WALK;
						end
					end
				end else if (start) begin
					phase_d = htld_pkg::PH_FLAG;
					sc_d    = sc;
					nc_d    = nc;
					if (ph == htld_pkg::PH_SYMBOL) begin
						if (node_full || stack_full) begin
							valid_d = 1'b1;
							kind_d  = htld_pkg::KIND_HDR_ERR;
							sc_d    = '0;
							nc_d    = '0;
						end else begin
							new_node.leaf = 1'b1;
							new_node.sym  = data;
							node_we       = 1'b1;
							node_waddr    = nc[htld_pkg::NODE_IDX_W-1:0];
							node_wdata    = new_node;
							stack_we      = 1'b1;
							stack_waddr   = sc[htld_pkg::STACK_IDX_W-1:0];
							stack_wdata   = nc[htld_pkg::NODE_IDX_W-1:0];
							top_idx_d     = nc[htld_pkg::NODE_IDX_W-1:0];
							top_node_d    = new_node;
							sc_d          = sc + htld_pkg::stack_cnt_t'(1);
							nc_d          = nc + htld_pkg::node_cnt_t'(1);
						end
					end else if (data == htld_pkg::FLAG_LEAF) begin
						phase_d = htld_pkg::PH_SYMBOL;
					end else if (data == htld_pkg::FLAG_END &&
						sc <= htld_pkg::stack_cnt_t'(1)) begin
						valid_d = 1'b1;
						if (sc == '0) begin
							kind_d = htld_pkg::KIND_HDR_ERR;
							nc_d   = '0;
						end else begin
							kind_d      = htld_pkg::KIND_HDR_DONE;
							phase_d     = htld_pkg::PH_DECODE;
							sc_d        = '0;
							root_node_d = top_node_q;
							cur_node_d  = top_node_q;
						end
					end else if (sc == '0) begin
						nc_d = nc;
					end else if (sc == htld_pkg::stack_cnt_t'(1) || node_full) begin
						valid_d = 1'b1;
						kind_d  = htld_pkg::KIND_HDR_ERR;
						sc_d    = '0;
						nc_d    = '0;
					end else begin
						state_d = htld_pkg::ST_MERGE;
					end
				end
			end
			htld_pkg::ST_MERGE: begin
				new_node.left  = stack_rd_q;
				new_node.right = top_idx_q;
				node_we        = 1'b1;
				node_wdata     = new_node;
				stack_we       = 1'b1;
				stack_waddr    = htld_pkg::stack_idx_t'(sc_q - htld_pkg::stack_cnt_t'(2));
				top_idx_d      = nc_q[htld_pkg::NODE_IDX_W-1:0];
				top_node_d     = new_node;
				sc_d           = sc_q - htld_pkg::stack_cnt_t'(1);
				nc_d           = nc_q + htld_pkg::node_cnt_t'(1);
				state_d        = htld_pkg::ST_IDLE;
			end
			htld_pkg::ST_WALK: begin
				if (node_rd_q.leaf) begin
					valid_d    = 1'b1;
					symbol_d   = node_rd_q.sym;
					cur_node_d = root_node_q;
				end else begin
					cur_node_d = node_rd_q;
				end
				state_d = htld_pkg::ST_IDLE;
			end
			default: begin
				state_d = htld_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy   = state_q != htld_pkg::ST_IDLE;
	assign valid  = valid_q;
	assign kind   = kind_q;
	assign symbol = symbol_q;

endmodule

### src/htld_checker.sv
`include "assert_macros.svh"

module htld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic [1:0] kind,
	input logic [7:0] symbol
);

	`HTLD_ASSERT(a_no_result_while_busy, clk, arst_n, valid |-> !busy)
	`HTLD_ASSERT_NEXT(a_busy_one_cycle, clk, arst_n, busy, !busy)
	`HTLD_ASSERT(a_busy_from_start, clk, arst_n, $rose(busy) |-> $past(start))
	`HTLD_ASSERT(a_status_symbol_zero, clk, arst_n, (valid && kind != htld_pkg::KIND_SYMBOL) |-> symbol == 8'd0)

endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.kind   (kind),
	.symbol (symbol)
);

### dv/tree_decode_checker.sv
`timescale 1ns / 1ps

module tree_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       req_type,
	input  logic [7:0] data,
	input  logic       valid,
	input  logic [1:0] kind,
	input  logic [7:0] symbol,
	output int         mismatches,
	output int         pending
);

	typedef struct packed {
		htld_pkg::kind_t kind;
		logic [7:0]      sym;
	} outcome_t;

	htld_pkg::node_t     tree_nodes [htld_pkg::NODE_SLOTS];
	htld_pkg::node_idx_t build_stk [htld_pkg::STACK_SLOTS];
	int                  stk_depth;
	int                  node_total;
	htld_pkg::phase_t    ld_phase;
	htld_pkg::node_idx_t root_node;
	htld_pkg::node_idx_t cur_node;
	outcome_t            expected_outcomes [$];

	task automatic load_or_walk(input logic r, input logic [7:0] d,
			output bit hit, output outcome_t res);
		htld_pkg::node_t     n;
		htld_pkg::node_idx_t nxt;
		hit = 1'b0;
		res.kind = htld_pkg::KIND_SYMBOL;
		res.sym = 8'd0;
		if (r) begin
			if (ld_phase == htld_pkg::PH_DECODE) begin
				n = tree_nodes[cur_node];
				if (!n.leaf) begin
					nxt = d[0] ? n.right : n.left;
					n = tree_nodes[nxt];
					cur_node = nxt;
				end
				if (n.leaf) begin
					cur_node = root_node;
					hit = 1'b1;
					res.sym = n.sym;
				end
			end
			return;
		end
		// drop the loaded tree on any header byte
		if (ld_phase == htld_pkg::PH_DECODE) begin
			stk_depth = 0;
			node_total = 0;
			ld_phase = htld_pkg::PH_FLAG;
		end
		if (ld_phase == htld_pkg::PH_SYMBOL) begin
			if (node_total >= htld_pkg::NODE_SLOTS || stk_depth >= htld_pkg::STACK_SLOTS) begin
				hit = 1'b1;
			end else begin
				tree_nodes[node_total] = '{leaf: 1'b1, sym: d, left: '0, right: '0};
				build_stk[stk_depth] = htld_pkg::node_idx_t'(node_total);
				node_total++;
				stk_depth++;
			end
			ld_phase = htld_pkg::PH_FLAG;
		end else if (d == htld_pkg::FLAG_LEAF) begin
			ld_phase = htld_pkg::PH_SYMBOL;
		end else if (d == htld_pkg::FLAG_END && stk_depth <= 1) begin
			if (stk_depth == 0) begin
				hit = 1'b1;
			end else begin
				root_node = build_stk[0];
				cur_node = build_stk[0];
				stk_depth = 0;
				ld_phase = htld_pkg::PH_DECODE;
				hit = 1'b1;
				res.kind = htld_pkg::KIND_HDR_DONE;
				return;
			end
		end else if (stk_depth == 1 ||
			(stk_depth >= 2 && node_total >= htld_pkg::NODE_SLOTS)) begin
			hit = 1'b1;
		end else if (stk_depth >= 2) begin
			tree_nodes[node_total] = '{leaf: 1'b0, sym: 8'd0,
				left: build_stk[stk_depth-2], right: build_stk[stk_depth-1]};
			stk_depth -= 2;
			build_stk[stk_depth] = htld_pkg::node_idx_t'(node_total);
			stk_depth++;
			node_total++;
		end
		if (hit) begin
			res.kind = htld_pkg::KIND_HDR_ERR;
			stk_depth = 0;
			node_total = 0;
			ld_phase = htld_pkg::PH_FLAG;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t res;
		bit       hit;
		if (!arst_n) begin
			stk_depth = 0;
			node_total = 0;
			ld_phase = htld_pkg::PH_FLAG;
			root_node = '0;
			cur_node = '0;
			expected_outcomes.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (valid !== 1'b0) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got kind %0d symbol %0h",
						$time, kind, symbol);
					mismatches++;
				end else begin
					want = expected_outcomes.pop_front();
					if (kind !== want.kind) begin
						$display("%0t: kind mismatch, expected %0d, got %0d",
							$time, want.kind, kind);
						mismatches++;
					end
					if (symbol !== want.sym) begin
						$display("%0t: symbol mismatch, expected %0h, got %0h",
							$time, want.sym, symbol);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				load_or_walk(req_type, data, hit, res);
				if (hit)
					expected_outcomes.push_back(res);
			end
			pending = expected_outcomes.size();
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_CODE   = 1'b1;
	localparam int   RANDOM_ITEMS = 800;

	typedef enum int {
		SEQ_TREE,
		SEQ_NOISE,
		SEQ_BROKEN,
		SEQ_FILL_STACK,
		SEQ_FILL_NODES_MERGE,
		SEQ_FILL_NODES_LEAF
	} seq_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       req_type = 1'b0;
	logic [7:0] data = 8'd0;
	logic       busy;
	logic       valid;
	logic [1:0] kind;
	logic [7:0] symbol;
	int         mismatches;
	int         pending;
	int         burst_left = 0;
	int         sent_items = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	huffman_tree_load_and_decode u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.data     (data),
		.valid    (valid),
		.kind     (kind),
		.symbol   (symbol)
	);

	tree_decode_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.data       (data),
		.valid      (valid),
		.kind       (kind),
		.symbol     (symbol),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic send_item(input logic r, input logic [7:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		start <= 1'b1;
		req_type <= r;
		data <= d;
		do @(posedge clk); while (busy);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_leaf(input logic [7:0] sym);
		send_item(REQ_HEADER, htld_pkg::FLAG_LEAF);
		send_item(REQ_HEADER, sym);
	endtask

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int        round;
		int        leaves_left;
		int        depth;
		seq_kind_t seq;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: ignored bits, header errors, one-leaf tree, reload while decoding
		send_item(REQ_CODE, 8'hFF);
		send_item(REQ_HEADER, htld_pkg::FLAG_END);
		send_item(REQ_HEADER, 8'hFF);
		send_leaf(8'hFF);
		send_item(REQ_HEADER, 8'h02);
		send_leaf(8'h00);
		send_item(REQ_HEADER, htld_pkg::FLAG_END);
		send_item(REQ_CODE, 8'hFE);
		send_item(REQ_CODE, 8'h01);
		send_leaf(8'hA5);
		send_leaf(8'h5A);
		send_item(REQ_HEADER, 8'h80);
		send_leaf(8'h80);
		send_item(REQ_HEADER, htld_pkg::FLAG_END);
		send_item(REQ_HEADER, htld_pkg::FLAG_END);
		send_item(REQ_CODE, 8'h01);
		send_item(REQ_CODE, 8'h00);
		send_item(REQ_CODE, 8'hFF);
		send_item(REQ_CODE, 8'h00);
		send_item(REQ_CODE, 8'h00);

		round = 0;
		while (sent_items < RANDOM_ITEMS) begin
			round++;
			if (round == 2) begin
				case ($urandom_range(0, 2))
					0: seq = SEQ_FILL_STACK;
					1: seq = SEQ_FILL_NODES_MERGE;
					default: seq = SEQ_FILL_NODES_LEAF;
				endcase
			end else if ($urandom_range(0, 9) < 8)
				seq = SEQ_TREE;
			else if ($urandom_range(0, 1) == 0)
				seq = SEQ_NOISE;
			else
				seq = SEQ_BROKEN;
			case (seq)
				SEQ_TREE: begin
					leaves_left = ($urandom_range(0, 9) == 0) ?
						$urandom_range(13, 60) : $urandom_range(1, 12);
					depth = 0;
					while (leaves_left > 0 || depth > 1) begin
						if (leaves_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
							send_leaf(8'($urandom));
							leaves_left--;
							depth++;
						end else begin
							send_item(REQ_HEADER, ($urandom_range(0, 3) == 0) ?
								htld_pkg::FLAG_END : 8'($urandom_range(2, 255)));
							depth--;
						end
					end
					send_item(REQ_HEADER, htld_pkg::FLAG_END);
					repeat ($urandom_range(4, 40)) begin
						send_item(REQ_CODE, 8'($urandom));
					end
				end
				SEQ_FILL_STACK: begin
					repeat (htld_pkg::STACK_SLOTS) send_leaf(8'($urandom));
					send_leaf(8'($urandom));
				end
				SEQ_FILL_NODES_MERGE, SEQ_FILL_NODES_LEAF: begin
					send_leaf(8'($urandom));
					repeat (htld_pkg::NODE_SLOTS / 2 - 1) begin
						send_leaf(8'($urandom));
						send_item(REQ_HEADER, 8'($urandom_range(2, 255)));
					end
					send_leaf(8'($urandom));
					if (seq == SEQ_FILL_NODES_MERGE)
						send_item(REQ_HEADER, 8'($urandom_range(2, 255)));
					else
						send_leaf(8'($urandom));
				end
				default: begin
					if (seq == SEQ_NOISE) begin
						repeat ($urandom_range(1, 8))
							send_item(1'($urandom), 8'($urandom));
					end else begin
						repeat ($urandom_range(0, 3)) send_leaf(8'($urandom));
						if ($urandom_range(0, 1) == 1)
							send_item(REQ_HEADER, htld_pkg::FLAG_LEAF);
						repeat ($urandom_range(1, 3)) send_item(REQ_CODE, 8'($urandom));
						send_item(REQ_HEADER, 8'($urandom_range(0, 3)));
					end
					// flush back to an empty loader
					repeat (10) send_item(REQ_HEADER, htld_pkg::FLAG_END);
				end
			endcase
		end

		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### huffman_tree_load_and_decode.f
+incdir+src
src/htld_pkg.sv
src/huffman_tree_load_and_decode.sv
src/htld_checker.sv
dv/tree_decode_checker.sv
dv/testbench.sv
